>>> hdl/assert_macros.svh
// assertion macros shared by the weighted mass matrix assembly rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define CHK_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hdl/wmma_pkg.sv
// package with types, codes and arithmetic helpers for the weighted mass matrix assembly
package wmma_pkg;

	localparam int MAX_NODES_DEF = 4;
	localparam int MAX_QUAD_DEF  = 16;

	localparam int REQ_TYPE_W = 3;
	localparam int NODE_IDX_W = 2;
	localparam int QUAD_IDX_W = 4;
	localparam int VALUE_W    = 32;
	localparam int GNODE_W    = 32;
	localparam int COEF_W     = 48;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int NODE_CNT_W = 3;
	localparam int QUAD_CNT_W = 5;

	localparam logic [REQ_TYPE_W-1:0] REQ_BASIS  = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_WEIGHT = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_COEF   = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_NODE   = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_CLOSE  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUAD_COUNT = 2'd1;

	localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 3'd4;
	localparam logic [QUAD_CNT_W-1:0] QUAD_COUNT_RST = 5'd4;

	typedef struct packed {
		logic                      valid;
		logic signed [ACC_W-1:0]   acc;
		logic signed [VALUE_W-1:0] det;
	} scale_req_t;

	typedef struct packed {
		logic                     valid;
		logic signed [COEF_W-1:0] coefficient;
	} scale_rsp_t;

	// q16.16 rounding to nearest, ties away from zero
	function automatic logic signed [47:0] round16(input logic signed [63:0] x);
		logic signed [63:0] t;
		t = x + (x[63] ? 64'sd32767 : 64'sd32768);
		return t[63:16];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [47:0] hi_lim;
		logic signed [47:0] lo_lim;
		hi_lim = 48'sd2147483647;
		lo_lim = -48'sd2147483648;
		if (x > hi_lim) begin
			return 32'sh7FFFFFFF;
		end else if (x < lo_lim) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

>>> hdl/wmma_ram.sv
// generic single write port ram with one registered read port
module wmma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/wmma_scale.sv
// determinant scaling of one accumulated entry with rounding and 48-bit saturation
`include "assert_macros.svh"

module wmma_scale import wmma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scale_req_t req,
	output scale_rsp_t rsp
);

	localparam logic [47:0] MAG_NEG_LIM = 48'h8000_0000_0000;
	localparam logic [47:0] MAG_POS_LIM = 48'h7FFF_FFFF_FFFF;

	logic        v_s1;
	logic        v_s2;
	logic [63:0] ma_s1;
	logic [31:0] md_s1;
	logic        neg_s1;
	logic [63:0] lo_s2;
	logic [63:0] hi_s2;
	logic        neg_s2;
	logic [63:0] ma_c;
	logic [31:0] md_c;
	logic [49:0] sum_c;
	logic [47:0] mag_c;
	logic [47:0] res_c;
	logic        valid_q;
	logic signed [COEF_W-1:0] coef_q;

	// operand magnitudes; the product sign is registered alongside them
	always_comb begin
		ma_c = req.acc[ACC_W-1] ? 64'(-req.acc) : 64'(req.acc);
		md_c = req.det[VALUE_W-1] ? 32'(-req.det) : 32'(req.det);
	end

	// combine partial products, round and saturate
	always_comb begin
		sum_c = {3'b000, hi_s2[30:0], 16'h0000} + {2'b00, lo_s2[63:16]} + 50'(lo_s2[15]);
		if (hi_s2 >= 64'h8000_0000) begin
			mag_c = MAG_NEG_LIM;
		end else if (sum_c > 50'(MAG_NEG_LIM)) begin
			mag_c = MAG_NEG_LIM;
		end else begin
			mag_c = sum_c[47:0];
		end
		if (neg_s2) begin
			res_c = 48'(-mag_c);
		end else if (mag_c > MAG_POS_LIM) begin
			res_c = MAG_POS_LIM;
		end else begin
			res_c = mag_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1    <= req.valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1  <= ma_c;
		md_s1  <= md_c;
		neg_s1 <= req.acc[ACC_W-1] ^ req.det[VALUE_W-1];
		lo_s2  <= ma_s1[31:0] * md_s1;
		hi_s2  <= ma_s1[63:32] * md_s1;
		neg_s2 <= neg_s1;
		coef_q <= res_c;
	end

	assign rsp.valid       = valid_q;
	assign rsp.coefficient = coef_q;

	`CHK_ASSERT(a_scale_latency, req.valid |-> ##3 rsp.valid, "scale result missing after request")
	`CHK_NEVER(a_scale_overlap, req.valid && (v_s1 || v_s2), "scale request while previous in flight")
	`CHK_ASSERT(a_scale_sign, rsp.valid |-> ($past(neg_s2) || !rsp.coefficient[COEF_W-1]), "positive entry came out negative")

endmodule

>>> hdl/weighted_mass_matrix_assembly_top.sv
// top level of the weighted mass matrix assembly: tables, quadrature pipeline and triplet output
//
// channel   direction  transfer                     payload
// request   in         start && !busy at clk edge   req_type node_index quad_index value global_node
// config    in         cfg_write at clk edge        cfg_index cfg_data
// triplet   out        result_strobe, one cycle     row_node col_node coefficient last
//
// load items are written straight into the tables
// a close steps through all nn*nn triplets in turn: each triplet walks nq quadrature points
// through one read port per table and a five stage multiply pipeline, then a three stage
// scaling unit
// busy stays high from a close transfer with a non-zero node count until the last triplet has been issued
// tables are not cleared by reset; no clearing pass is run
// triplets cannot be held off by the receiver
`include "assert_macros.svh"

module weighted_mass_matrix_assembly_top import wmma_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_QUAD  = MAX_QUAD_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [REQ_TYPE_W-1:0]     req_type,
	input  logic [NODE_IDX_W-1:0]     node_index,
	input  logic [QUAD_IDX_W-1:0]     quad_index,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [GNODE_W-1:0]        global_node,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      result_strobe,
	output logic [GNODE_W-1:0]        row_node,
	output logic [GNODE_W-1:0]        col_node,
	output logic signed [COEF_W-1:0]  coefficient,
	output logic                      last
);

	localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int QW   = (MAX_QUAD > 1) ? $clog2(MAX_QUAD) : 1;
	localparam int BD   = MAX_NODES * MAX_QUAD;
	localparam int BW   = (BD > 1) ? $clog2(BD) : 1;
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int QCW  = $clog2(MAX_QUAD + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_SCALE = 2'd3;

	logic [1:0]            state_q;
	logic [NODE_CNT_W-1:0] node_count_q;
	logic [QUAD_CNT_W-1:0] quad_count_q;
	logic [NW-1:0]         a_q;
	logic [NW-1:0]         b_q;
	logic [QCW-1:0]        q_q;
	logic [NCW-1:0]        nn;
	logic [QCW-1:0]        nq;
	logic                  accept;
	logic                  node_ok;
	logic                  quad_ok;
	logic                  issue;
	logic                  last_entry;
	logic                  b_wrap;
	logic                  scale_go_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [VALUE_W-1:0]        phi_a_s1;
	logic [VALUE_W-1:0]        phi_b_s1;
	logic [VALUE_W-1:0]        wgt_s1;
	logic [VALUE_W-1:0]        coef_s1;
	logic [GNODE_W-1:0]        gnode_a;
	logic [GNODE_W-1:0]        gnode_b;
	logic signed [63:0]        pp_prod_s2;
	logic signed [63:0]        cw_prod_s2;
	logic signed [31:0]        pp_s3;
	logic signed [31:0]        cw_s3;
	logic signed [63:0]        term_prod_s4;
	logic signed [47:0]        term_s5;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [VALUE_W-1:0] det_q;

	logic                     strobe_q;
	logic [GNODE_W-1:0]       row_q;
	logic [GNODE_W-1:0]       col_q;
	logic signed [COEF_W-1:0] coef_q;
	logic                     last_q;

	scale_req_t sc_req;
	scale_rsp_t sc_rsp;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign node_ok = (32'(node_index) < MAX_NODES);
	assign quad_ok = (32'(quad_index) < MAX_QUAD);

	assign nn = (32'(node_count_q) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_q);
	assign nq = (32'(quad_count_q) > MAX_QUAD) ? QCW'(MAX_QUAD) : QCW'(quad_count_q);

	assign issue      = (state_q == ST_ISSUE) && (q_q < nq);
	assign b_wrap     = (32'(b_q) + 1 == 32'(nn));
	assign last_entry = (32'(a_q) + 1 == 32'(nn)) && b_wrap;

	// tables
	wmma_ram #(.WIDTH(VALUE_W), .DEPTH(BD)) u_basis_a (
		.clk   (clk),
		.we    (accept && req_type == REQ_BASIS && node_ok && quad_ok),
		.waddr (BW'(32'(node_index) * MAX_QUAD + 32'(quad_index))),
		.wdata (value),
		.raddr (BW'(32'(a_q) * MAX_QUAD + 32'(q_q))),
		.rdata (phi_a_s1)
	);

	wmma_ram #(.WIDTH(VALUE_W), .DEPTH(BD)) u_basis_b (
		.clk   (clk),
		.we    (accept && req_type == REQ_BASIS && node_ok && quad_ok),
		.waddr (BW'(32'(node_index) * MAX_QUAD + 32'(quad_index))),
		.wdata (value),
		.raddr (BW'(32'(b_q) * MAX_QUAD + 32'(q_q))),
		.rdata (phi_b_s1)
	);

	wmma_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_QUAD)) u_weight (
		.clk   (clk),
		.we    (accept && req_type == REQ_WEIGHT && quad_ok),
		.waddr (QW'(quad_index)),
		.wdata (value),
		.raddr (QW'(q_q)),
		.rdata (wgt_s1)
	);

	wmma_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_QUAD)) u_coef (
		.clk   (clk),
		.we    (accept && req_type == REQ_COEF && quad_ok),
		.waddr (QW'(quad_index)),
		.wdata (value),
		.raddr (QW'(q_q)),
		.rdata (coef_s1)
	);

	wmma_ram #(.WIDTH(GNODE_W), .DEPTH(MAX_NODES)) u_nodes_a (
		.clk   (clk),
		.we    (accept && req_type == REQ_NODE && node_ok),
		.waddr (NW'(node_index)),
		.wdata (global_node),
		.raddr (a_q),
		.rdata (gnode_a)
	);

	wmma_ram #(.WIDTH(GNODE_W), .DEPTH(MAX_NODES)) u_nodes_b (
		.clk   (clk),
		.we    (accept && req_type == REQ_NODE && node_ok),
		.waddr (NW'(node_index)),
		.wdata (global_node),
		.raddr (b_q),
		.rdata (gnode_b)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			quad_count_q <= QUAD_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data[NODE_CNT_W-1:0];
				CFG_QUAD_COUNT: quad_count_q <= cfg_data[QUAD_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer over test node, trial node and quadrature point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			a_q        <= '0;
			b_q        <= '0;
			q_q        <= '0;
			scale_go_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			scale_go_q <= 1'b0;
			v_s1       <= issue;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			strobe_q   <= sc_rsp.valid;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_CLOSE && nn != '0) begin
						state_q <= ST_ISSUE;
						a_q     <= '0;
						b_q     <= '0;
						q_q     <= '0;
					end
				end
				ST_ISSUE: begin
					if (q_q < nq) begin
						q_q <= q_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4 || v_s5)) begin
						state_q    <= ST_SCALE;
						scale_go_q <= 1'b1;
					end
				end
				ST_SCALE: begin
					if (sc_rsp.valid) begin
						if (last_entry) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							q_q     <= '0;
							if (b_wrap) begin
								b_q <= '0;
								a_q <= a_q + 1'b1;
							end else begin
								b_q <= b_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// quadrature pipeline and accumulator
	always_ff @(posedge clk) begin
		pp_prod_s2   <= $signed(phi_a_s1) * $signed(phi_b_s1);
		cw_prod_s2   <= $signed(coef_s1) * $signed(wgt_s1);
		pp_s3        <= sat32(round16(pp_prod_s2));
		cw_s3        <= sat32(round16(cw_prod_s2));
		term_prod_s4 <= pp_s3 * cw_s3;
		term_s5      <= round16(term_prod_s4);
		if (state_q == ST_IDLE || state_q == ST_SCALE) begin
			acc_q <= '0;
		end else if (v_s5) begin
			acc_q <= acc_q + {{(ACC_W - 48){term_s5[47]}}, term_s5};
		end
		if (accept && req_type == REQ_CLOSE) begin
			det_q <= value;
		end
		if (sc_rsp.valid) begin
			row_q  <= gnode_a;
			col_q  <= gnode_b;
			coef_q <= sc_rsp.coefficient;
			last_q <= last_entry;
		end
	end

	assign sc_req.valid = scale_go_q;
	assign sc_req.acc   = acc_q;
	assign sc_req.det   = det_q;

	wmma_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sc_req),
		.rsp    (sc_rsp)
	);

	assign result_strobe = strobe_q;
	assign row_node      = row_q;
	assign col_node      = col_q;
	assign coefficient   = coef_q;
	assign last          = last_q;

	`CHK_ASSERT(a_strobe_gap, result_strobe |=> !result_strobe, "triplets on adjacent cycles")
	`CHK_ASSERT(a_more_pending, result_strobe && !last |-> busy, "idle before last triplet")
	`CHK_NEVER(a_scale_early, scale_go_q && (v_s1 || v_s5), "scaling started before pipeline drained")
	`CHK_ASSERT(a_quad_bound, state_q == ST_ISSUE |-> 32'(q_q) <= 32'(nq), "quadrature counter overran")

endmodule
